>>> hdl/pbi_pkg.sv
// pbi_pkg: codes, character constants and controller states for the pbrain core.
// Depends on nothing; used by pbi_apb, the core and the testbench.
package pbi_pkg;

    // request commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;
    localparam logic [1:0] CMD_SUPPLY = 2'd3;

    // result events
    localparam logic [2:0] EV_OK      = 3'd0;
    localparam logic [2:0] EV_OUT     = 3'd1;
    localparam logic [2:0] EV_NEED    = 3'd2;
    localparam logic [2:0] EV_HALT    = 3'd3;
    localparam logic [2:0] EV_BUDGET  = 3'd4;
    localparam logic [2:0] EV_IGNORED = 3'd5;

    // program characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [31:0] BUDGET_RESET = 32'd65536;

    // comment skipper phases
    localparam logic [1:0] CMT_FIRST = 2'd0;
    localparam logic [1:0] CMT_LINE  = 2'd1;
    localparam logic [1:0] CMT_BLOCK = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_CALL,
        ST_RET,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_BACK_RD,
        ST_BACK_CK,
        ST_CMT_RD,
        ST_CMT_CK,
        ST_DONE
    } state_t;

endpackage

>>> hdl/pbi_if.sv
// pbi_if: request and result channel interfaces of the pbrain core.
// Depends on nothing.
interface pbi_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [13:0] prog_addr;
    logic [7:0]  data_byte;
    logic        end_of_input;

    modport source (output valid, command, prog_addr, data_byte, end_of_input, input ready);
    modport sink   (input valid, command, prog_addr, data_byte, end_of_input, output ready);
endinterface

interface pbi_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [13:0] stop_pc;

    modport source (output valid, event_res, out_byte, stop_pc, input ready);
    modport sink   (input valid, event_res, out_byte, stop_pc, output ready);
endinterface

>>> hdl/pbi_ram.sv
// pbi_ram: single write port, single read port synchronous RAM with registered read data.
// Depends on nothing.
module pbi_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/pbi_apb.sv
// pbi_apb: APB configuration port holding the step budget register.
// Depends on pbi_pkg.
module pbi_apb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] step_budget
);

    logic [31:0] budget_reg;
    logic [31:0] budget_next;

    assign pready      = 1'b1;
    assign step_budget = budget_reg;
    assign prdata      = (paddr == 3'd0) ? budget_reg : 32'd0;

    always_comb
    begin
        budget_next = budget_reg;
        if (psel && penable && pwrite && (paddr == 3'd0))
        begin
            budget_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= pbi_pkg::BUDGET_RESET;
        end
        else
        begin
            budget_reg <= budget_next;
        end
    end

endmodule

>>> hdl/pbrain_interpreter_core.sv
// pbrain_interpreter_core: pbrain (brainfuck with procedures) interpreter.
// Depends on pbi_pkg, pbi_if, pbi_ram and pbi_apb.
//
// One request is taken at a time and gives one result. A run fetches and
// decodes program bytes one at a time, the byte it stops on included;
// bracket, procedure and comment scans walk the program byte by byte, and
// ':' into a defined procedure and ')' with a non-empty stack pass through
// an extra call or return state; every instruction fetch is a program RAM
// and tape RAM read. Start clears the whole tape in a sweep. After reset a
// sweep clears the whole program store and tape; no request is taken
// meanwhile, while APB writes are served at any time.
module pbrain_interpreter_core #(
    parameter int PROG_DEPTH  = 16384,
    parameter int TAPE_CELLS  = 65536,
    parameter int STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    pbi_cmd_if.sink     cmd,
    pbi_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PA_W      = $clog2(PROG_DEPTH);
    localparam int PC_W      = $clog2(PROG_DEPTH + 1);
    localparam int QW        = PC_W + 1;
    localparam int TW        = $clog2(TAPE_CELLS);
    localparam int SA_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int MAX_CELLS = (PROG_DEPTH > TAPE_CELLS) ? PROG_DEPTH : TAPE_CELLS;
    localparam int CLR_W     = $clog2(MAX_CELLS);

    logic [31:0] step_budget;

    pbi_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .step_budget (step_budget)
    );

    // registers
    pbi_pkg::state_t  state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [TW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             await_reg, await_next;
    logic             fin_reg, fin_next;
    logic [31:0]      steps_reg, steps_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [PC_W-1:0]  depth_reg, depth_next;
    logic             paren_reg, paren_next;
    logic [1:0]       cphase_reg, cphase_next;
    logic             star_reg, star_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic             sweep_prog_reg, sweep_prog_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [255:0]     pv_reg, pv_next;
    logic [2:0]       ev_reg, ev_next;
    logic [7:0]       byte_reg, byte_next;
    logic             ovalid_reg, ovalid_next;
    logic [2:0]       oev_reg, oev_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic [13:0]      opc_reg, opc_next;

    // memory ports
    logic             prog_we;
    logic [PA_W-1:0]  prog_waddr;
    logic [7:0]       prog_wdata;
    logic [QW-1:0]    prog_rfull;
    logic [7:0]       prog_q;
    logic             tape_we;
    logic [TW-1:0]    tape_waddr;
    logic [7:0]       tape_wdata;
    logic [TW-1:0]    tape_raddr;
    logic [7:0]       tape_q;
    logic             tbl_we;
    logic [7:0]       tbl_addr_w;
    logic [PA_W-1:0]  tbl_wdata;
    logic [7:0]       tbl_raddr;
    logic [PA_W-1:0]  tbl_q;
    logic             stk_we;
    logic [SA_W-1:0]  stk_waddr;
    logic [PA_W-1:0]  stk_wdata;
    logic [SA_W-1:0]  stk_raddr;
    logic [PA_W-1:0]  stk_q;

    pbi_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8), .AW(PA_W)) u_prog (
        .clk (clk), .we (prog_we), .waddr (prog_waddr), .wdata (prog_wdata),
        .raddr (prog_rfull[PA_W-1:0]), .rdata (prog_q)
    );

    pbi_ram #(.DEPTH(TAPE_CELLS), .WIDTH(8), .AW(TW)) u_tape (
        .clk (clk), .we (tape_we), .waddr (tape_waddr), .wdata (tape_wdata),
        .raddr (tape_raddr), .rdata (tape_q)
    );

    pbi_ram #(.DEPTH(256), .WIDTH(PA_W), .AW(8)) u_table (
        .clk (clk), .we (tbl_we), .waddr (tbl_addr_w), .wdata (tbl_wdata),
        .raddr (tbl_raddr), .rdata (tbl_q)
    );

    pbi_ram #(.DEPTH(STACK_DEPTH), .WIDTH(PA_W), .AW(SA_W)) u_stack (
        .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
        .raddr (stk_raddr), .rdata (stk_q)
    );

    function automatic logic [PC_W-1:0] clamp_pc(input logic [QW-1:0] a);
        logic [PC_W-1:0] r;
        if (a > QW'(PROG_DEPTH))
        begin
            r = PC_W'(PROG_DEPTH);
        end
        else
        begin
            r = a[PC_W-1:0];
        end
        return r;
    endfunction

    logic [7:0]  fbyte;
    logic [7:0]  cur_cell;
    logic [7:0]  open_ch;
    logic [7:0]  close_ch;
    logic [31:0] pc_ext;

    assign fbyte    = rd_ok_reg ? prog_q : 8'd0;
    assign cur_cell = tape_q;
    assign open_ch  = paren_reg ? pbi_pkg::CH_LPAR : pbi_pkg::CH_LBRK;
    assign close_ch = paren_reg ? pbi_pkg::CH_RPAR : pbi_pkg::CH_RBRK;
    assign pc_ext   = 32'(pc_next);

    assign cmd.ready     = (state_reg == pbi_pkg::ST_IDLE);
    assign res.valid     = ovalid_reg;
    assign res.event_res = oev_reg;
    assign res.out_byte  = obyte_reg;
    assign res.stop_pc   = opc_reg;

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        await_next      = await_reg;
        fin_next        = fin_reg;
        steps_next      = steps_reg;
        q_next          = q_reg;
        depth_next      = depth_reg;
        paren_next      = paren_reg;
        cphase_next     = cphase_reg;
        star_next       = star_reg;
        clr_next        = clr_reg;
        sweep_prog_next = sweep_prog_reg;
        pv_next         = pv_reg;
        ev_next         = ev_reg;
        byte_next       = byte_reg;
        ovalid_next     = ovalid_reg && !res.ready;
        oev_next        = oev_reg;
        obyte_next      = obyte_reg;
        opc_next        = opc_reg;

        prog_we    = 1'b0;
        prog_waddr = PA_W'(cmd.prog_addr);
        prog_wdata = cmd.data_byte;
        prog_rfull = QW'(pc_reg);
        tape_we    = 1'b0;
        tape_waddr = ptr_reg;
        tape_wdata = 8'd0;
        tape_raddr = ptr_reg;
        tbl_we     = 1'b0;
        tbl_addr_w = cur_cell;
        tbl_wdata  = PA_W'(pc_reg);
        tbl_raddr  = cur_cell;
        stk_we     = 1'b0;
        stk_waddr  = SA_W'(cnt_reg);
        stk_wdata  = PA_W'(pc_reg);
        stk_raddr  = SA_W'(cnt_reg - CW'(1));

        case (state_reg)
            pbi_pkg::ST_CLEAR:
            begin
                prog_we    = sweep_prog_reg && ({1'b0, clr_reg} < (CLR_W + 1)'(PROG_DEPTH));
                prog_waddr = PA_W'(clr_reg);
                prog_wdata = 8'd0;
                tape_we    = {1'b0, clr_reg} < (CLR_W + 1)'(TAPE_CELLS);
                tape_waddr = TW'(clr_reg);
                clr_next   = clr_reg + CLR_W'(1);
                if (sweep_prog_reg && (clr_reg == CLR_W'(MAX_CELLS - 1)))
                begin
                    sweep_prog_next = 1'b0;
                    state_next      = pbi_pkg::ST_IDLE;
                end
                else if (!sweep_prog_reg && (clr_reg == CLR_W'(TAPE_CELLS - 1)))
                begin
                    state_next = pbi_pkg::ST_DONE;
                end
            end

            pbi_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    byte_next  = 8'd0;
                    ev_next    = pbi_pkg::EV_OK;
                    state_next = pbi_pkg::ST_DONE;
                    case (cmd.command)
                        pbi_pkg::CMD_LOAD:
                        begin
                            if (32'(cmd.prog_addr) < 32'(PROG_DEPTH))
                            begin
                                prog_we = 1'b1;
                            end
                            else
                            begin
                                ev_next = pbi_pkg::EV_IGNORED;
                            end
                        end
                        pbi_pkg::CMD_START:
                        begin
                            pv_next    = '0;
                            pc_next    = '0;
                            ptr_next   = '0;
                            cnt_next   = '0;
                            await_next = 1'b0;
                            fin_next   = 1'b0;
                            clr_next   = '0;
                            state_next = pbi_pkg::ST_CLEAR;
                        end
                        pbi_pkg::CMD_RUN:
                        begin
                            if (fin_reg)
                            begin
                                ev_next = pbi_pkg::EV_HALT;
                            end
                            else if (await_reg)
                            begin
                                ev_next = pbi_pkg::EV_NEED;
                            end
                            else
                            begin
                                steps_next = '0;
                                state_next = pbi_pkg::ST_FETCH;
                            end
                        end
                        default:
                        begin
                            if (await_reg)
                            begin
                                tape_we    = 1'b1;
                                tape_wdata = cmd.end_of_input ? 8'd0 : cmd.data_byte;
                                await_next = 1'b0;
                                pc_next    = clamp_pc(QW'(pc_reg) + QW'(1));
                            end
                            else
                            begin
                                ev_next = pbi_pkg::EV_IGNORED;
                            end
                        end
                    endcase
                end
            end

            pbi_pkg::ST_FETCH:
            begin
                prog_rfull = QW'(pc_reg);
                state_next = pbi_pkg::ST_DECODE;
            end

            pbi_pkg::ST_DECODE:
            begin
                if (fbyte == 8'd0)
                begin
                    fin_next   = 1'b1;
                    ev_next    = pbi_pkg::EV_HALT;
                    state_next = pbi_pkg::ST_DONE;
                end
                else if (steps_reg == step_budget)
                begin
                    ev_next    = pbi_pkg::EV_BUDGET;
                    state_next = pbi_pkg::ST_DONE;
                end
                else
                begin
                    steps_next = steps_reg + 32'd1;
                    pc_next    = clamp_pc(QW'(pc_reg) + QW'(1));
                    state_next = pbi_pkg::ST_FETCH;
                    q_next     = QW'(pc_reg);
                    depth_next = PC_W'(1);
                    case (fbyte)
                        pbi_pkg::CH_DOT:
                        begin
                            byte_next  = cur_cell;
                            ev_next    = pbi_pkg::EV_OUT;
                            state_next = pbi_pkg::ST_DONE;
                        end
                        pbi_pkg::CH_COMMA:
                        begin
                            pc_next    = pc_reg;
                            await_next = 1'b1;
                            ev_next    = pbi_pkg::EV_NEED;
                            state_next = pbi_pkg::ST_DONE;
                        end
                        pbi_pkg::CH_PLUS:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = cur_cell + 8'd1;
                        end
                        pbi_pkg::CH_MINUS:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = cur_cell - 8'd1;
                        end
                        pbi_pkg::CH_RIGHT:
                        begin
                            ptr_next = (ptr_reg == TW'(TAPE_CELLS - 1)) ? '0 : ptr_reg + TW'(1);
                        end
                        pbi_pkg::CH_LEFT:
                        begin
                            ptr_next = (ptr_reg == '0) ? TW'(TAPE_CELLS - 1) : ptr_reg - TW'(1);
                        end
                        pbi_pkg::CH_LBRK:
                        begin
                            if (cur_cell == 8'd0)
                            begin
                                pc_next    = pc_reg;
                                paren_next = 1'b0;
                                state_next = pbi_pkg::ST_SCAN_RD;
                            end
                        end
                        pbi_pkg::CH_RBRK:
                        begin
                            if (cur_cell != 8'd0)
                            begin
                                pc_next    = pc_reg;
                                state_next = pbi_pkg::ST_BACK_RD;
                            end
                        end
                        pbi_pkg::CH_LPAR:
                        begin
                            tbl_we      = 1'b1;
                            pv_next[cur_cell] = 1'b1;
                            pc_next     = pc_reg;
                            paren_next  = 1'b1;
                            state_next  = pbi_pkg::ST_SCAN_RD;
                        end
                        pbi_pkg::CH_RPAR:
                        begin
                            if (cnt_reg != '0)
                            begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = pbi_pkg::ST_RET;
                            end
                        end
                        pbi_pkg::CH_COLON:
                        begin
                            if (cnt_reg < CW'(STACK_DEPTH))
                            begin
                                stk_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            if (pv_reg[cur_cell])
                            begin
                                state_next = pbi_pkg::ST_CALL;
                            end
                        end
                        pbi_pkg::CH_SLASH:
                        begin
                            pc_next     = pc_reg;
                            q_next      = QW'(pc_reg) + QW'(1);
                            cphase_next = pbi_pkg::CMT_FIRST;
                            state_next  = pbi_pkg::ST_CMT_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            pbi_pkg::ST_CALL:
            begin
                pc_next    = clamp_pc(QW'(tbl_q) + QW'(1));
                state_next = pbi_pkg::ST_FETCH;
            end

            pbi_pkg::ST_RET:
            begin
                pc_next    = clamp_pc(QW'(stk_q) + QW'(1));
                state_next = pbi_pkg::ST_FETCH;
            end

            pbi_pkg::ST_SCAN_RD:
            begin
                prog_rfull = q_reg + QW'(1);
                q_next     = q_reg + QW'(1);
                state_next = pbi_pkg::ST_SCAN_CK;
            end

            pbi_pkg::ST_SCAN_CK:
            begin
                state_next = pbi_pkg::ST_SCAN_RD;
                if (fbyte == 8'd0)
                begin
                    fin_next   = 1'b1;
                    ev_next    = pbi_pkg::EV_HALT;
                    state_next = pbi_pkg::ST_DONE;
                end
                else if (fbyte == open_ch)
                begin
                    depth_next = depth_reg + PC_W'(1);
                end
                else if (fbyte == close_ch)
                begin
                    if (depth_reg == PC_W'(1))
                    begin
                        pc_next    = clamp_pc(q_reg + QW'(1));
                        state_next = pbi_pkg::ST_FETCH;
                    end
                    else
                    begin
                        depth_next = depth_reg - PC_W'(1);
                    end
                end
            end

            pbi_pkg::ST_BACK_RD:
            begin
                prog_rfull = q_reg - QW'(1);
                if (q_reg == '0)
                begin
                    fin_next   = 1'b1;
                    ev_next    = pbi_pkg::EV_HALT;
                    state_next = pbi_pkg::ST_DONE;
                end
                else
                begin
                    q_next     = q_reg - QW'(1);
                    state_next = pbi_pkg::ST_BACK_CK;
                end
            end

            pbi_pkg::ST_BACK_CK:
            begin
                state_next = pbi_pkg::ST_BACK_RD;
                if (fbyte == pbi_pkg::CH_RBRK)
                begin
                    depth_next = depth_reg + PC_W'(1);
                end
                else if (fbyte == pbi_pkg::CH_LBRK)
                begin
                    if (depth_reg == PC_W'(1))
                    begin
                        pc_next    = clamp_pc(q_reg + QW'(1));
                        state_next = pbi_pkg::ST_FETCH;
                    end
                    else
                    begin
                        depth_next = depth_reg - PC_W'(1);
                    end
                end
            end

            pbi_pkg::ST_CMT_RD:
            begin
                prog_rfull = q_reg;
                state_next = pbi_pkg::ST_CMT_CK;
            end

            pbi_pkg::ST_CMT_CK:
            begin
                state_next = pbi_pkg::ST_CMT_RD;
                q_next     = q_reg + QW'(1);
                case (cphase_reg)
                    pbi_pkg::CMT_FIRST:
                    begin
                        if (fbyte == pbi_pkg::CH_SLASH)
                        begin
                            cphase_next = pbi_pkg::CMT_LINE;
                        end
                        else if (fbyte == pbi_pkg::CH_STAR)
                        begin
                            cphase_next = pbi_pkg::CMT_BLOCK;
                            star_next   = 1'b0;
                        end
                        else
                        begin
                            // lone slash: plain one-byte step
                            pc_next    = clamp_pc(QW'(pc_reg) + QW'(1));
                            state_next = pbi_pkg::ST_FETCH;
                        end
                    end
                    pbi_pkg::CMT_LINE:
                    begin
                        if (fbyte == 8'd0)
                        begin
                            pc_next    = clamp_pc(q_reg);
                            state_next = pbi_pkg::ST_FETCH;
                        end
                        else if (fbyte == pbi_pkg::CH_NL)
                        begin
                            pc_next    = clamp_pc(q_reg + QW'(1));
                            state_next = pbi_pkg::ST_FETCH;
                        end
                    end
                    default:
                    begin
                        if (fbyte == 8'd0)
                        begin
                            pc_next    = clamp_pc(q_reg);
                            state_next = pbi_pkg::ST_FETCH;
                        end
                        else if (star_reg && (fbyte == pbi_pkg::CH_SLASH))
                        begin
                            pc_next    = clamp_pc(q_reg + QW'(1));
                            state_next = pbi_pkg::ST_FETCH;
                        end
                        else
                        begin
                            star_next = (fbyte == pbi_pkg::CH_STAR);
                        end
                    end
                endcase
            end

            pbi_pkg::ST_DONE:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    oev_next    = ev_reg;
                    obyte_next  = byte_reg;
                    opc_next    = 14'(pc_reg);
                    state_next  = pbi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pbi_pkg::ST_IDLE;
            end
        endcase

        rd_ok_next = prog_rfull < QW'(PROG_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbi_pkg::ST_CLEAR;
            pc_reg         <= '0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            await_reg      <= 1'b0;
            fin_reg        <= 1'b0;
            clr_reg        <= '0;
            sweep_prog_reg <= 1'b1;
            pv_reg         <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            await_reg      <= await_next;
            fin_reg        <= fin_next;
            clr_reg        <= clr_next;
            sweep_prog_reg <= sweep_prog_next;
            pv_reg         <= pv_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg  <= steps_next;
        q_reg      <= q_next;
        depth_reg  <= depth_next;
        paren_reg  <= paren_next;
        cphase_reg <= cphase_next;
        star_reg   <= star_next;
        rd_ok_reg  <= rd_ok_next;
        ev_reg     <= ev_next;
        byte_reg   <= byte_next;
        oev_reg    <= oev_next;
        obyte_reg  <= obyte_next;
        opc_reg    <= opc_next;
    end

    // pc_ext only feeds the range check below
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_ext <= 32'(PROG_DEPTH))
        else $error("pc beyond program end");

    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(fin_reg && await_reg))
        else $error("finished while waiting for input");

    a_stack_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(STACK_DEPTH))
        else $error("stack count overflow");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("second request taken before result");

    a_tape_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < 32'(TAPE_CELLS))
        else $error("tape pointer out of range");

endmodule

>>> verif/pbrain_interpreter_core_tb.sv
// Self-checking testbench for pbrain_interpreter_core: directed and random pbrain
// programs, with a behavioral predictor and an in-order result scoreboard.
// Depends on pbi_pkg, pbi_if and the core RTL.
`timescale 1ns / 100ps

module pbrain_interpreter_core_tb;

    localparam int PROG_CELLS = 16384;
    localparam int TAPE_SIZE  = 65536;
    localparam int STK_SIZE   = 256;
    localparam logic [2:0] BUDGET_ADDR = 3'd0;

    typedef struct {
        logic [2:0]  ev;
        logic [7:0]  ob;
        logic [13:0] pc;
    } core_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    pbi_cmd_if cmd_ch();
    pbi_res_if res_ch();

    pbrain_interpreter_core DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch.sink), .res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow machine state
    logic [7:0]  prog_mem [PROG_CELLS];
    logic [7:0]  tape_mem [TAPE_SIZE];
    int unsigned proc_addr [256];
    bit          proc_ok [256];
    int unsigned ret_stk [STK_SIZE];
    int unsigned pc_m, ptr_m, depth_m;
    bit          wait_in, done_m;
    logic [31:0] budget_m;

    core_result_t expected_results[$];
    int  errors;
    int  sent_items;
    int  seen_results;
    bit  idle_en;
    string prog_chars = "++--<>>..,,[[]](():/*\n x+-";

    always #5 clk = ~clk;

    function automatic logic [7:0] fetch_byte(int unsigned a);
        return a < PROG_CELLS ? prog_mem[a] : 8'd0;
    endfunction

    function automatic int unsigned clamp_addr(int unsigned a);
        return a > PROG_CELLS ? PROG_CELLS : a;
    endfunction

    function automatic bit match_forward(inout int unsigned pos, input logic [7:0] op,
                                         input logic [7:0] cl);
        int unsigned p, d;
        logic [7:0] b;
        p = pos;
        d = 1;
        while (d != 0)
        begin
            p++;
            b = fetch_byte(p);
            if (b == 8'd0) return 1'b0;
            if (b == op) d++;
            else if (b == cl) d--;
        end
        pos = p;
        return 1'b1;
    endfunction

    function automatic bit match_back(inout int unsigned pos);
        int unsigned p, d;
        logic [7:0] b;
        p = pos;
        d = 1;
        while (d != 0)
        begin
            if (p == 0) return 1'b0;
            p--;
            b = fetch_byte(p);
            if (b == pbi_pkg::CH_RBRK) d++;
            else if (b == pbi_pkg::CH_LBRK) d--;
        end
        pos = p;
        return 1'b1;
    endfunction

    function automatic void clear_machine();
        for (int i = 0; i < TAPE_SIZE; i++) tape_mem[i] = 8'd0;
        for (int i = 0; i < 256; i++)
        begin
            proc_addr[i] = 0;
            proc_ok[i] = 1'b0;
        end
        for (int i = 0; i < STK_SIZE; i++) ret_stk[i] = 0;
        pc_m = 0;
        ptr_m = 0;
        depth_m = 0;
        wait_in = 1'b0;
        done_m = 1'b0;
    endfunction

    function automatic logic [2:0] interpret(output logic [7:0] emitted);
        logic [31:0] n;
        int unsigned pc, q;
        logic [7:0] b, c, nx, cur;
        n = 0;
        emitted = 8'd0;
        forever
        begin
            pc = pc_m;
            b = fetch_byte(pc);
            cur = tape_mem[ptr_m];
            if (b == 8'd0)
            begin
                done_m = 1'b1;
                return pbi_pkg::EV_HALT;
            end
            if (n == budget_m) return pbi_pkg::EV_BUDGET;
            n++;
            case (b)
                pbi_pkg::CH_DOT:
                begin
                    emitted = cur;
                    pc_m = pc + 1;
                    return pbi_pkg::EV_OUT;
                end
                pbi_pkg::CH_COMMA:
                begin
                    wait_in = 1'b1;
                    return pbi_pkg::EV_NEED;
                end
                pbi_pkg::CH_PLUS:  tape_mem[ptr_m] = cur + 8'd1;
                pbi_pkg::CH_MINUS: tape_mem[ptr_m] = cur - 8'd1;
                pbi_pkg::CH_RIGHT: ptr_m = (ptr_m + 1 >= TAPE_SIZE) ? 0 : ptr_m + 1;
                pbi_pkg::CH_LEFT:  ptr_m = (ptr_m == 0) ? TAPE_SIZE - 1 : ptr_m - 1;
                pbi_pkg::CH_LBRK:
                begin
                    if (cur == 8'd0 && !match_forward(pc, pbi_pkg::CH_LBRK, pbi_pkg::CH_RBRK))
                    begin
                        done_m = 1'b1;
                        return pbi_pkg::EV_HALT;
                    end
                end
                pbi_pkg::CH_RBRK:
                begin
                    if (cur != 8'd0 && !match_back(pc))
                    begin
                        done_m = 1'b1;
                        return pbi_pkg::EV_HALT;
                    end
                end
                pbi_pkg::CH_LPAR:
                begin
                    proc_addr[cur] = pc;
                    proc_ok[cur] = 1'b1;
                    if (!match_forward(pc, pbi_pkg::CH_LPAR, pbi_pkg::CH_RPAR))
                    begin
                        done_m = 1'b1;
                        return pbi_pkg::EV_HALT;
                    end
                end
                pbi_pkg::CH_RPAR:
                begin
                    if (depth_m > 0)
                    begin
                        depth_m--;
                        pc = ret_stk[depth_m % STK_SIZE];
                    end
                end
                pbi_pkg::CH_COLON:
                begin
                    if (depth_m < STK_SIZE)
                    begin
                        ret_stk[depth_m] = pc;
                        depth_m++;
                    end
                    if (proc_ok[cur]) pc = proc_addr[cur];
                end
                pbi_pkg::CH_SLASH:
                begin
                    nx = fetch_byte(pc + 1);
                    q = pc + 2;
                    if (nx == pbi_pkg::CH_SLASH)
                    begin
                        while (fetch_byte(q) != 8'd0 && fetch_byte(q) != pbi_pkg::CH_NL) q++;
                        if (fetch_byte(q) == pbi_pkg::CH_NL) q++;
                        pc_m = clamp_addr(q);
                        continue;
                    end
                    if (nx == pbi_pkg::CH_STAR)
                    begin
                        forever
                        begin
                            c = fetch_byte(q);
                            if (c == 8'd0) break;
                            if (c == pbi_pkg::CH_STAR && fetch_byte(q + 1) == pbi_pkg::CH_SLASH)
                            begin
                                q += 2;
                                break;
                            end
                            q++;
                        end
                        pc_m = clamp_addr(q);
                        continue;
                    end
                end
                default: ;
            endcase
            pc_m = clamp_addr(pc + 1);
        end
    endfunction

    function automatic core_result_t predict_result(logic [1:0] op, logic [13:0] addr,
                                                    logic [7:0] data, logic eoi);
        core_result_t r;
        logic [7:0] em;
        r.ev = pbi_pkg::EV_OK;
        r.ob = 8'd0;
        case (op)
            pbi_pkg::CMD_LOAD: prog_mem[addr] = data;
            pbi_pkg::CMD_START: clear_machine();
            pbi_pkg::CMD_RUN:
            begin
                if (done_m) r.ev = pbi_pkg::EV_HALT;
                else if (wait_in) r.ev = pbi_pkg::EV_NEED;
                else
                begin
                    r.ev = interpret(em);
                    r.ob = em;
                end
            end
            default:
            begin
                if (wait_in)
                begin
                    tape_mem[ptr_m] = eoi ? 8'd0 : data;
                    wait_in = 1'b0;
                    pc_m = clamp_addr(pc_m + 1);
                end
                else
                begin
                    r.ev = pbi_pkg::EV_IGNORED;
                end
            end
        endcase
        r.pc = pc_m[13:0];
        return r;
    endfunction

    // send one request; valid is left high so a following request can go back to back
    task automatic send_request(logic [1:0] op, logic [13:0] addr, logic [7:0] data, logic eoi);
        if (idle_en)
            while ($urandom_range(99) < 13)
            begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
            end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= op;
        cmd_ch.prog_addr    <= addr;
        cmd_ch.data_byte    <= data;
        cmd_ch.end_of_input <= eoi;
        do @(posedge clk); while (!cmd_ch.ready);
        expected_results.push_back(predict_result(op, addr, data, eoi));
        sent_items++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BUDGET_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_budget(logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        budget_m = value;
        @(posedge clk);
        apb_access(1'b0, 32'd0, rd);
        if (rd !== budget_m)
        begin
            $error("step_budget readback: expected %0h actual %0h", budget_m, rd);
            errors++;
        end
        @(posedge clk);
    endtask

    task automatic load_text(string text, int base);
        for (int i = 0; i < text.len(); i++)
            send_request(pbi_pkg::CMD_LOAD, 14'(base + i), text[i], 1'b0);
        send_request(pbi_pkg::CMD_LOAD, 14'(base + text.len()), 8'd0, 1'b0);
    endtask

    task automatic test_reset_defaults();
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== pbi_pkg::BUDGET_RESET)
        begin
            $error("step_budget after reset: expected %0h actual %0h",
                   pbi_pkg::BUDGET_RESET, rd);
            errors++;
        end
        @(posedge clk);
    endtask

    // wrap left, input wait, repeated run, eoi, stray supply, procedure call and
    // return, empty return, line and block comments, lone slash, then halt
    task automatic test_directed();
        int k;
        set_budget(32'hFFFF_FFFF);
        load_text("<,.(+.):)/ //\n/**/[-]", 0);
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_SUPPLY, 14'd0, 8'hFF, 1'b0);
        send_request(pbi_pkg::CMD_SUPPLY, 14'd0, 8'h00, 1'b1);
        k = 0;
        while (!done_m && k < 8)
        begin
            send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
            k++;
        end
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_LOAD, 14'h3FFF, 8'hFF, 1'b0);
        send_request(pbi_pkg::CMD_LOAD, 14'h3FFF, 8'h00, 1'b0);
        wait_drained();
        set_budget(32'd1);
        send_request(pbi_pkg::CMD_START, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_SUPPLY, 14'd0, 8'h5A, 1'b1);
        load_text(",.", 0);
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_SUPPLY, 14'd0, 8'h00, 1'b1);
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_programs();
        int len, nb, np, cnt, r, phase;
        bit fix;
        logic [7:0] code [64];
        phase = 0;
        while (sent_items < 1750)
        begin
            wait_drained();
            idle_en = (phase != 4);
            if (phase == 0) set_budget(32'd1);
            else if (phase == 5) set_budget(32'd300);
            else set_budget($urandom_range(64, 1));
            send_request(pbi_pkg::CMD_START, 14'd0, 8'd0, 1'b0);
            len = $urandom_range(40, 6);
            fix = $urandom_range(99) < 80;
            nb = 0;
            np = 0;
            for (int i = 0; i < len; i++)
            begin
                code[i] = prog_chars[$urandom_range(prog_chars.len() - 1)];
                if (fix)
                begin
                    if (code[i] == pbi_pkg::CH_LBRK) nb++;
                    if (code[i] == pbi_pkg::CH_LPAR) np++;
                    if (code[i] == pbi_pkg::CH_RBRK)
                    begin
                        if (nb == 0) code[i] = pbi_pkg::CH_PLUS;
                        else nb--;
                    end
                    if (code[i] == pbi_pkg::CH_RPAR)
                    begin
                        if (np == 0) code[i] = pbi_pkg::CH_MINUS;
                        else np--;
                    end
                end
            end
            for (int i = 0; i < nb + np && len < 64; i++)
            begin
                code[len] = (i < nb) ? pbi_pkg::CH_RBRK : pbi_pkg::CH_RPAR;
                len++;
            end
            for (int i = 0; i < len; i++)
                send_request(pbi_pkg::CMD_LOAD, 14'(i), code[i], 1'b0);
            send_request(pbi_pkg::CMD_LOAD, 14'(len), 8'd0, 1'b0);
            cnt = 0;
            while (cnt < 170 && !done_m)
            begin
                if (phase == 2 && cnt == 40) wait_drained();
                r = $urandom_range(99);
                if (r < 62)
                    send_request(pbi_pkg::CMD_RUN, 14'($urandom), 8'($urandom), 1'($urandom));
                else if (r < 84)
                    send_request(pbi_pkg::CMD_SUPPLY, 14'($urandom), 8'($urandom),
                                 $urandom_range(3) == 0);
                else if (r < 94)
                    send_request(pbi_pkg::CMD_LOAD, 14'($urandom_range(len - 1)),
                                 prog_chars[$urandom_range(prog_chars.len() - 1)], 1'b0);
                else
                    send_request(pbi_pkg::CMD_LOAD, 14'($urandom_range(16383, len + 1)),
                                 8'($urandom), 1'b0);
                cnt++;
            end
            send_request(pbi_pkg::CMD_RUN, 14'd0, 8'd0, 1'b0);
            phase++;
        end
        wait_drained();
    endtask

    // result scoreboard
    always @(posedge clk)
    begin : score
        core_result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            seen_results++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: event_res %0d", res_ch.event_res);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.event_res !== want.ev)
                begin
                    $error("event_res: expected %0d actual %0d", want.ev, res_ch.event_res);
                    errors++;
                end
                if (res_ch.out_byte !== want.ob)
                begin
                    $error("out_byte: expected %0h actual %0h", want.ob, res_ch.out_byte);
                    errors++;
                end
                if (res_ch.stop_pc !== want.pc)
                begin
                    $error("stop_pc: expected %0d actual %0d", want.pc, res_ch.stop_pc);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        res_ch.ready <= !idle_en || ($urandom_range(99) >= 13);

    initial
    begin
        #2_000_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = pbi_pkg::CMD_LOAD;
        cmd_ch.prog_addr = '0;
        cmd_ch.data_byte = '0;
        cmd_ch.end_of_input = 1'b0;
        errors = 0;
        sent_items = 0;
        seen_results = 0;
        idle_en = 1'b1;
        for (int i = 0; i < PROG_CELLS; i++) prog_mem[i] = 8'd0;
        clear_machine();
        budget_m = pbi_pkg::BUDGET_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_programs();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        $display("Ran %0d requests (load, start, run, supply) over random pbrain programs,",
                 sent_items);
        $display("budgets from 1 to max, %0d results checked, %0d errors.",
                 seen_results, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
